FILE: rtl/arpc_pkg.sv
// shared types and constants of the arp cache next-hop resolver
package arpc_pkg;

	localparam logic [1:0] CMD_LEARN   = 2'd0;
	localparam logic [1:0] CMD_RESOLVE = 2'd1;
	localparam logic [1:0] CMD_ARP     = 2'd2;

	localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
	localparam logic [1:0] REG_SUBNET_MASK = 2'd1;
	localparam logic [1:0] REG_GATEWAY_IP  = 2'd2;

	localparam logic [31:0] LOCAL_IP_RESET    = 32'h0A00_020F;
	localparam logic [31:0] SUBNET_MASK_RESET = 32'hFFFF_FF00;
	localparam logic [31:0] GATEWAY_IP_RESET  = 32'h0A00_0202;

	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] peer_ip;
		logic [47:0] peer_mac;
		logic [15:0] arp_opcode;
		logic [31:0] arp_target_ip;
	} arpc_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] next_hop_ip;
		logic [47:0] hop_mac;
		logic        reply_needed;
		logic [3:0]  entry_slot;
	} arpc_rsp_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} arpc_entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} arpc_state_t;

endpackage

FILE: rtl/arpc_table.sv
// entry memory: address and mac of each table entry, one write and one read port
module arpc_table #(
	parameter int TABLE_ENTRIES = 16,
	parameter int IW = 4
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [IW-1:0]        rd_addr,
	output arpc_pkg::arpc_entry_t rd_data,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_addr,
	input  arpc_pkg::arpc_entry_t wr_data
);

	arpc_pkg::arpc_entry_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/arpc_ctrl.sv
// command sequencer: config registers, valid bits, table scan and write-back
module arpc_ctrl #(
	parameter int TABLE_ENTRIES = 16,
	parameter int IW = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  arpc_pkg::arpc_req_t   req,
	output logic                  done,
	output arpc_pkg::arpc_rsp_t   rsp,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [31:0]           cfg_wdata,
	output logic                  rd_en,
	output logic [IW-1:0]         rd_addr,
	input  arpc_pkg::arpc_entry_t rd_data,
	output logic                  wr_en,
	output logic [IW-1:0]         wr_addr,
	output arpc_pkg::arpc_entry_t wr_data
);

	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	arpc_pkg::arpc_state_t state_q, state_d;

	logic [31:0] local_ip_q, mask_q, gw_q;
	logic [1:0]  cmd_q;
	logic [31:0] key_q;
	logic [47:0] mac_q;
	logic        reply_q;
	logic [IW-1:0] scan_q;
	logic        issue_done_q;
	logic        chk_vld_s1;
	logic [IW-1:0] chk_idx_s1;
	logic [IW-1:0] free_q;
	logic        free_fnd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic        done_q;
	arpc_pkg::arpc_rsp_t rsp_q, rsp_d;

	logic [31:0] route;
	logic        accept, chk_valid, match, chk_last, fin, is_learn;
	logic [IW-1:0] free_slot;

	assign accept    = start && (state_q == arpc_pkg::ST_IDLE);
	assign route     = ((req.peer_ip & mask_q) == (local_ip_q & mask_q)) ? req.peer_ip : gw_q;
	assign chk_valid = valid_q[chk_idx_s1];
	assign match     = chk_vld_s1 && chk_valid && (rd_data.ip == key_q);
	assign chk_last  = (chk_idx_s1 == LAST);
	assign fin       = chk_vld_s1 && (match || chk_last);
	assign is_learn  = (cmd_q == arpc_pkg::CMD_LEARN) || (cmd_q == arpc_pkg::CMD_ARP);
	// first free entry, or entry 0 when the table is full
	assign free_slot = free_fnd_q ? free_q : (!chk_valid ? chk_idx_s1 : '0);

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = scan_q;
		wr_en   = 1'b0;
		wr_addr = match ? chk_idx_s1 : free_slot;
		wr_data = '{ip: key_q, mac: mac_q};
		rsp_d   = '0;
		unique case (state_q)
			arpc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = arpc_pkg::ST_SCAN;
				end
			end
			arpc_pkg::ST_SCAN: begin
				rd_en = !issue_done_q;
				wr_en = fin && is_learn;
				if (fin) begin
					state_d = arpc_pkg::ST_IDLE;
				end
			end
			default: state_d = arpc_pkg::ST_IDLE;
		endcase
		case (cmd_q) inside
			arpc_pkg::CMD_RESOLVE: begin
				rsp_d.hit          = match;
				rsp_d.next_hop_ip  = key_q;
				rsp_d.hop_mac      = match ? rd_data.mac : arpc_pkg::BCAST_MAC;
				rsp_d.entry_slot   = match ? 4'(chk_idx_s1) : 4'd0;
			end
			arpc_pkg::CMD_LEARN, arpc_pkg::CMD_ARP: begin
				rsp_d.entry_slot   = 4'(wr_addr);
				rsp_d.reply_needed = reply_q;
			end
			default: rsp_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= arpc_pkg::LOCAL_IP_RESET;
			mask_q     <= arpc_pkg::SUBNET_MASK_RESET;
			gw_q       <= arpc_pkg::GATEWAY_IP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				arpc_pkg::REG_LOCAL_IP:    local_ip_q <= cfg_wdata;
				arpc_pkg::REG_SUBNET_MASK: mask_q     <= cfg_wdata;
				arpc_pkg::REG_GATEWAY_IP:  gw_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			free_fnd_q   <= 1'b0;
			valid_q      <= '0;
			done_q       <= 1'b0;
			scan_q       <= '0;
		end else begin
			done_q     <= (state_q == arpc_pkg::ST_SCAN) && fin;
			chk_vld_s1 <= rd_en && !fin;
			if (accept) begin
				scan_q       <= '0;
				issue_done_q <= 1'b0;
				free_fnd_q   <= 1'b0;
			end else begin
				if (rd_en) begin
					if (scan_q == LAST) begin
						issue_done_q <= 1'b1;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				if (chk_vld_s1 && !chk_valid && !free_fnd_q) begin
					free_fnd_q <= 1'b1;
				end
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.command;
			key_q   <= (req.command == arpc_pkg::CMD_RESOLVE) ? route : req.peer_ip;
			mac_q   <= req.peer_mac;
			reply_q <= (req.command == arpc_pkg::CMD_ARP) &&
				(req.arp_opcode == arpc_pkg::ARP_OP_REQUEST) &&
				(req.arp_target_ip == local_ip_q);
		end
		chk_idx_s1 <= scan_q;
		if (chk_vld_s1 && !chk_valid && !free_fnd_q) begin
			free_q <= chk_idx_s1;
		end
		if (fin) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = (state_q != arpc_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is still running");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a finished scan");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command did not start a scan");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == arpc_pkg::ST_SCAN) && fin)
		else $error("table write outside the end of a scan");

endmodule

FILE: rtl/arp_cache_next_hop_resolver.sv
// top level of the arp cache with subnet next-hop resolution
//
// Usage: a command (learn, resolve, received arp message) is transferred at a
// rising edge with start high and busy low. busy stays high while the table
// is scanned. Each command yields one result on rsp, valid for exactly one
// cycle while done is high; the receiver cannot stall, so it must take it.
// Scan: the table is read one entry per cycle from the entry memory (one
// read port, registered read data) and each entry is compared the cycle after. A scan
// stops at the first entry that matches; a miss, or any learn that creates
// a new entry, scans the whole table. The table write happens in the
// same cycle as the final compare. A new command can be transferred in the
// cycle that done is high, so commands never overlap: the next one is
// taken once the result of the last one is out.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and
// are meant for idle periods. Reset clears all valid bits and reloads the
// register defaults; the entry memory itself is not cleared.
module arp_cache_next_hop_resolver #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  arpc_pkg::arpc_req_t req,
	output logic                done,
	output arpc_pkg::arpc_rsp_t rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [31:0]         cfg_wdata
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic                  rd_en, wr_en;
	logic [IW-1:0]         rd_addr, wr_addr;
	arpc_pkg::arpc_entry_t rd_data, wr_data;

	arpc_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IW(IW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	arpc_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IW(IW)
	) u_table (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule

FILE: verif/tb.sv
// self-checking testbench for the arp cache next-hop resolver
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 16;
	localparam int RAND_ITEMS = 650;
	localparam int PHASES = 6;
	localparam int POOL_SIZE = 24;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	arpc_pkg::arpc_req_t req = '0;
	logic                done;
	arpc_pkg::arpc_rsp_t rsp;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_addr = arpc_pkg::REG_LOCAL_IP;
	logic [31:0]         cfg_wdata = '0;

	arp_cache_next_hop_resolver #(
		.TABLE_ENTRIES(ENTRIES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// shadow copy of the cache and its registers
	logic        cache_valid [ENTRIES];
	logic [31:0] cache_ip    [ENTRIES];
	logic [47:0] cache_mac   [ENTRIES];
	logic [31:0] own_ip;
	logic [31:0] net_mask;
	logic [31:0] gw_ip;
	logic [31:0] addr_pool [POOL_SIZE];

	arpc_pkg::arpc_rsp_t answer_q[$];
	bit                  use_known;
	arpc_pkg::arpc_rsp_t known_rsp;

	int err_cnt = 0;
	int n_learn = 0;
	int n_resolve = 0;
	int n_arp = 0;
	int n_unused = 0;
	int n_hit = 0;
	int n_reply = 0;
	int n_evict = 0;
	int n_settings = 0;

	typedef struct {
		arpc_pkg::arpc_req_t cmd;
		bit                  known;
		arpc_pkg::arpc_rsp_t rsp;
	} step_row_t;

	step_row_t plan[$];

	function automatic int find_slot(logic [31:0] ip);
		for (int i = 0; i < ENTRIES; i++)
			if (cache_valid[i] && cache_ip[i] == ip)
				return i;
		return -1;
	endfunction

	function automatic int store_mapping(logic [31:0] ip, logic [47:0] mac);
		int slot;
		slot = find_slot(ip);
		if (slot < 0) begin
			slot = 0;
			while (slot < ENTRIES && cache_valid[slot])
				slot++;
			// full table: entry 0 is replaced
			if (slot == ENTRIES) begin
				slot = 0;
				n_evict++;
			end
			cache_ip[slot] = ip;
			cache_valid[slot] = 1'b1;
		end
		cache_mac[slot] = mac;
		return slot;
	endfunction

	function automatic arpc_pkg::arpc_rsp_t cache_answer(arpc_pkg::arpc_req_t r);
		arpc_pkg::arpc_rsp_t a;
		logic [31:0]         hop;
		int                  slot;
		a = '0;
		case (r.command)
			arpc_pkg::CMD_LEARN: begin
				n_learn++;
				a.entry_slot = 4'(store_mapping(r.peer_ip, r.peer_mac));
			end
			arpc_pkg::CMD_RESOLVE: begin
				n_resolve++;
				hop = ((r.peer_ip & net_mask) == (own_ip & net_mask)) ? r.peer_ip : gw_ip;
				slot = find_slot(hop);
				a.next_hop_ip = hop;
				if (slot >= 0) begin
					n_hit++;
					a.hit = 1'b1;
					a.hop_mac = cache_mac[slot];
					a.entry_slot = 4'(slot);
				end else begin
					a.hop_mac = arpc_pkg::BCAST_MAC;
				end
			end
			arpc_pkg::CMD_ARP: begin
				n_arp++;
				a.entry_slot = 4'(store_mapping(r.peer_ip, r.peer_mac));
				if (r.arp_opcode == arpc_pkg::ARP_OP_REQUEST &&
						r.arp_target_ip == own_ip) begin
					a.reply_needed = 1'b1;
					n_reply++;
				end
			end
			default: n_unused++;
		endcase
		return a;
	endfunction

	function automatic arpc_pkg::arpc_req_t mk_req(logic [1:0] c, logic [31:0] ip,
			logic [47:0] mac, logic [15:0] op, logic [31:0] tgt);
		arpc_pkg::arpc_req_t r;
		r.command = c;
		r.peer_ip = ip;
		r.peer_mac = mac;
		r.arp_opcode = op;
		r.arp_target_ip = tgt;
		return r;
	endfunction

	function automatic arpc_pkg::arpc_rsp_t mk_rsp(logic h, logic [31:0] ip,
			logic [47:0] mac, logic rep, logic [3:0] slot);
		arpc_pkg::arpc_rsp_t a;
		a.hit = h;
		a.next_hop_ip = ip;
		a.hop_mac = mac;
		a.reply_needed = rep;
		a.entry_slot = slot;
		return a;
	endfunction

	function automatic void add_row(arpc_pkg::arpc_req_t c, bit known,
			arpc_pkg::arpc_rsp_t a);
		step_row_t row;
		row.cmd = c;
		row.known = known;
		row.rsp = a;
		plan.push_back(row);
	endfunction

	function automatic arpc_pkg::arpc_req_t rand_cmd();
		arpc_pkg::arpc_req_t r;
		int                  pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			r.command = arpc_pkg::CMD_LEARN;
		else if (pick < 68)
			r.command = arpc_pkg::CMD_RESOLVE;
		else if (pick < 95)
			r.command = arpc_pkg::CMD_ARP;
		else
			r.command = CMD_UNUSED;
		r.peer_ip = ($urandom_range(0, 4) == 0) ? $urandom
			: addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		r.peer_mac = {16'($urandom), 32'($urandom)};
		if ($urandom_range(0, 9) == 0)
			r.arp_opcode = 16'($urandom);
		else if ($urandom_range(0, 3) == 0)
			r.arp_opcode = 16'd2;
		else
			r.arp_opcode = arpc_pkg::ARP_OP_REQUEST;
		if ($urandom_range(0, 1) == 0)
			r.arp_target_ip = own_ip;
		else if ($urandom_range(0, 1) == 0)
			r.arp_target_ip = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			r.arp_target_ip = $urandom;
		return r;
	endfunction

	// addresses mostly on the current subnet so that lookups hit and the table fills
	function automatic void build_pool();
		addr_pool[0] = gw_ip;
		addr_pool[1] = own_ip;
		for (int i = 2; i < 18; i++)
			addr_pool[i] = (own_ip & net_mask) | ($urandom_range(0, 40) & ~net_mask);
		for (int i = 18; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
		err_cnt++;
		if (err_cnt <= 10)
			$display("mismatch %0s at %0t: expected %h, got %h", what, $time, want_v, got_v);
	endtask

	task automatic check_answer(arpc_pkg::arpc_rsp_t want, arpc_pkg::arpc_rsp_t got);
		if (got.hit !== want.hit)
			note_mismatch("hit", 64'(want.hit), 64'(got.hit));
		if (got.next_hop_ip !== want.next_hop_ip)
			note_mismatch("next_hop_ip", 64'(want.next_hop_ip), 64'(got.next_hop_ip));
		if (got.hop_mac !== want.hop_mac)
			note_mismatch("hop_mac", 64'(want.hop_mac), 64'(got.hop_mac));
		if (got.reply_needed !== want.reply_needed)
			note_mismatch("reply_needed", 64'(want.reply_needed), 64'(got.reply_needed));
		if (got.entry_slot !== want.entry_slot)
			note_mismatch("entry_slot", 64'(want.entry_slot), 64'(got.entry_slot));
	endtask

	// results first, then a new transfer in the same cycle
	always @(posedge clk) begin : monitor
		arpc_pkg::arpc_rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (answer_q.size() == 0)
					note_mismatch("unexpected result", 64'd0, 64'(rsp));
				else
					check_answer(answer_q.pop_front(), rsp);
			end
			if (start && !busy) begin
				want = cache_answer(req);
				if (use_known)
					want = known_rsp;
				answer_q.push_back(want);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_cmd(arpc_pkg::arpc_req_t c, bit known, arpc_pkg::arpc_rsp_t a);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		use_known = known;
		known_rsp = a;
		start <= 1'b1;
		req <= c;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (answer_q.size() != 0 || busy)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic program_regs(logic [31:0] l, logic [31:0] m, logic [31:0] g);
		cfg_we <= 1'b1;
		cfg_addr <= arpc_pkg::REG_LOCAL_IP;
		cfg_wdata <= l;
		own_ip = l;
		@(negedge clk);
		cfg_addr <= arpc_pkg::REG_SUBNET_MASK;
		cfg_wdata <= m;
		net_mask = m;
		@(negedge clk);
		cfg_addr <= arpc_pkg::REG_GATEWAY_IP;
		cfg_wdata <= g;
		gw_ip = g;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		n_settings++;
	endtask

	initial begin : stimulus
		logic [31:0] l;
		logic [31:0] m;
		logic [31:0] g;
		int          per_phase;
		for (int i = 0; i < ENTRIES; i++) begin
			cache_valid[i] = 1'b0;
			cache_ip[i] = '0;
			cache_mac[i] = '0;
		end
		own_ip = arpc_pkg::LOCAL_IP_RESET;
		net_mask = arpc_pkg::SUBNET_MASK_RESET;
		gw_ip = arpc_pkg::GATEWAY_IP_RESET;
		use_known = 1'b0;
		known_rsp = '0;

		// directed part, register defaults after reset
		add_row(mk_req(arpc_pkg::CMD_RESOLVE, 32'h0A00_0205, '0, '0, '0), 1,
			mk_rsp(1'b0, 32'h0A00_0205, arpc_pkg::BCAST_MAC, 1'b0, 4'd0));
		add_row(mk_req(arpc_pkg::CMD_RESOLVE, 32'h0808_0808, '0, '0, '0), 1,
			mk_rsp(1'b0, arpc_pkg::GATEWAY_IP_RESET, arpc_pkg::BCAST_MAC, 1'b0, 4'd0));
		add_row(mk_req(arpc_pkg::CMD_LEARN, arpc_pkg::GATEWAY_IP_RESET,
			48'h0011_2233_4455, '0, '0), 1,
			mk_rsp(1'b0, '0, '0, 1'b0, 4'd0));
		add_row(mk_req(arpc_pkg::CMD_RESOLVE, 32'h0808_0808, '0, '0, '0), 1,
			mk_rsp(1'b1, arpc_pkg::GATEWAY_IP_RESET, 48'h0011_2233_4455, 1'b0, 4'd0));
		add_row(mk_req(CMD_UNUSED, '1, '1, '1, '1), 1, mk_rsp(1'b0, '0, '0, 1'b0, 4'd0));
		add_row(mk_req(arpc_pkg::CMD_ARP, 32'h0A00_0203, arpc_pkg::BCAST_MAC,
			arpc_pkg::ARP_OP_REQUEST, arpc_pkg::LOCAL_IP_RESET), 1,
			mk_rsp(1'b0, '0, '0, 1'b1, 4'd1));
		add_row(mk_req(arpc_pkg::CMD_ARP, 32'h0A00_0203, '0, 16'd2,
			arpc_pkg::LOCAL_IP_RESET), 1,
			mk_rsp(1'b0, '0, '0, 1'b0, 4'd1));
		add_row(mk_req(arpc_pkg::CMD_RESOLVE, 32'h0A00_0203, '1, '0, '0), 1,
			mk_rsp(1'b1, 32'h0A00_0203, '0, 1'b0, 4'd1));
		add_row(mk_req(arpc_pkg::CMD_ARP, '1, 48'hAAAA_5555_AAAA, '1, '1), 0, '0);
		add_row(mk_req(arpc_pkg::CMD_LEARN, '0, '0, '0, '0), 0, '0);
		add_row(mk_req(arpc_pkg::CMD_ARP, 32'h0A00_02FF, 48'h5555_AAAA_5555,
			arpc_pkg::ARP_OP_REQUEST, '0), 0, '0);
		add_row(mk_req(arpc_pkg::CMD_RESOLVE, '0, '0, '0, '0), 0, '0);
		add_row(mk_req(arpc_pkg::CMD_LEARN, arpc_pkg::GATEWAY_IP_RESET,
			arpc_pkg::BCAST_MAC, '0, '0), 1,
			mk_rsp(1'b0, '0, '0, 1'b0, 4'd0));
		for (int i = 0; i < 11; i++)
			add_row(mk_req(arpc_pkg::CMD_LEARN, 32'h0A00_0210 + i, 48'(i + 1), '0, '0),
				0, '0);
		// table is full now: a new address lands in entry 0 and the gateway is gone
		add_row(mk_req(arpc_pkg::CMD_LEARN, 32'hC0A8_0001, 48'hDEAD_BEEF_0001, '0, '0), 1,
			mk_rsp(1'b0, '0, '0, 1'b0, 4'd0));
		add_row(mk_req(arpc_pkg::CMD_RESOLVE, 32'h0808_0808, '0, '0, '0), 1,
			mk_rsp(1'b0, arpc_pkg::GATEWAY_IP_RESET, arpc_pkg::BCAST_MAC, 1'b0, 4'd0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_cmd(plan[i].cmd, plan[i].known, plan[i].rsp);

		per_phase = RAND_ITEMS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin
					l = arpc_pkg::LOCAL_IP_RESET;
					m = arpc_pkg::SUBNET_MASK_RESET;
					g = arpc_pkg::GATEWAY_IP_RESET;
				end
				1: begin
					// zero mask: every destination is local
					l = '1;
					m = '0;
					g = '0;
				end
				2: begin
					l = '0;
					m = '1;
					g = '1;
				end
				3: begin
					l = 32'hC0A8_0164;
					m = 32'hFFFF_0000;
					g = 32'hC0A8_0001;
				end
				4: begin
					l = $urandom;
					m = 32'hFFFF_FFFF << $urandom_range(0, 32);
					g = (l & m) | ($urandom & ~m);
				end
				default: begin
					l = $urandom;
					m = $urandom;
					g = $urandom;
				end
			endcase
			program_regs(l, m, g);
			build_pool();
			repeat (per_phase)
				send_cmd(rand_cmd(), 1'b0, '0);
		end

		settle();
		repeat (ENTRIES + 4) @(negedge clk);
		$display("run covered %0d commands: %0d learn, %0d resolve, %0d arp, %0d unused",
			n_learn + n_resolve + n_arp + n_unused, n_learn, n_resolve, n_arp, n_unused);
		$display("%0d resolve hits, %0d arp replies, %0d full-table evictions, %0d settings",
			n_hit, n_reply, n_evict, n_settings);
		if (err_cnt == 0 && answer_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing", err_cnt, answer_q.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("timeout with %0d results outstanding", answer_q.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
